>>> src/bmse_pkg.sv
// Shared types, codes and constants for the batch-means standard error block.
// Used by bmse_iter and batch_means_std_error; depends on nothing.
`default_nettype none

package bmse_pkg;

    localparam int SAMPLE_W = 48;   // sample, mean and last_sample width
    localparam int SE_W     = 47;   // standard error width
    localparam int CFG_W    = 17;   // configuration register width
    localparam int ACC_W    = 64;   // batch and means accumulators
    localparam int WIDE_W   = 128;  // sum of squares and unit operand
    localparam int ROOT_W   = 64;   // square root result
    localparam int REM_W    = 68;   // unit partial remainder
    localparam int CNT_W    = 8;    // unit step counter

    // input transaction op codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;

    // configuration register byte addresses
    localparam logic [2:0] REG_PPB_ADDR     = 3'd0;
    localparam logic [2:0] REG_BATCHES_ADDR = 3'd4;

    typedef enum logic [2:0] {
        U_MUL  = 3'b001,
        U_DIV  = 3'b010,
        U_SQRT = 3'b100
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

>>> src/bmse_iter.sv
// Shared shift/add/subtract unit: squaring multiply, restoring divide, integer square root.
// One bit (or one root digit) per cycle; depends on bmse_pkg.
`default_nettype none

module bmse_iter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire bmse_pkg::unit_cmd_t              cmd,
    input  wire logic [bmse_pkg::WIDE_W-1:0]      opnd_a,
    input  wire logic [bmse_pkg::CFG_W-1:0]       divisor,
    output bmse_pkg::unit_stat_t                  stat,
    output logic [bmse_pkg::WIDE_W-1:0]           result
);

    bmse_pkg::unit_op_t                 op_reg;
    logic [bmse_pkg::WIDE_W-1:0]        work_reg;
    logic [bmse_pkg::REM_W-1:0]         rem_reg;
    logic [bmse_pkg::ROOT_W-1:0]        aux_reg;
    logic [bmse_pkg::CNT_W-1:0]         cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [bmse_pkg::WIDE_W-1:0]        mul_next;
    logic [bmse_pkg::CFG_W:0]           div_top;
    logic [bmse_pkg::CFG_W:0]           div_d;
    logic                               div_ge;
    logic [bmse_pkg::REM_W-1:0]         sq_top;
    logic [bmse_pkg::REM_W-1:0]         sq_trial;
    logic                               sq_ge;
    logic [bmse_pkg::CNT_W-1:0]         cnt_last;

    // MSB-first shift and add of the multiplicand
    assign mul_next = {work_reg[bmse_pkg::WIDE_W-2:0], 1'b0}
                    + (rem_reg[bmse_pkg::ROOT_W-1]
                       ? {{(bmse_pkg::WIDE_W-bmse_pkg::ROOT_W){1'b0}}, aux_reg}
                       : '0);

    assign div_top = {rem_reg[bmse_pkg::CFG_W-1:0], work_reg[bmse_pkg::WIDE_W-1]};
    assign div_d   = {1'b0, aux_reg[bmse_pkg::CFG_W-1:0]};
    assign div_ge  = (div_top >= div_d);

    assign sq_top   = {rem_reg[bmse_pkg::REM_W-3:0], work_reg[bmse_pkg::WIDE_W-1 -: 2]};
    assign sq_trial = {2'b00, aux_reg, 2'b01};
    assign sq_ge    = (sq_top >= sq_trial);

    always_comb begin
        unique case (op_reg)
            bmse_pkg::U_DIV: cnt_last = bmse_pkg::CNT_W'(bmse_pkg::WIDE_W - 1);
            default:         cnt_last = bmse_pkg::CNT_W'(bmse_pkg::ROOT_W - 1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !cmd.start && (cnt_reg == cnt_last);
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= cmd.op;
                unique case (cmd.op)
                    bmse_pkg::U_MUL: begin
                        work_reg <= '0;
                        rem_reg  <= {{(bmse_pkg::REM_W-bmse_pkg::ROOT_W){1'b0}},
                                     opnd_a[bmse_pkg::ROOT_W-1:0]};
                        aux_reg  <= opnd_a[bmse_pkg::ROOT_W-1:0];
                    end
                    bmse_pkg::U_DIV: begin
                        work_reg <= opnd_a;
                        rem_reg  <= '0;
                        aux_reg  <= {{(bmse_pkg::ROOT_W-bmse_pkg::CFG_W){1'b0}}, divisor};
                    end
                    default: begin
                        work_reg <= opnd_a;
                        rem_reg  <= '0;
                        aux_reg  <= '0;
                    end
                endcase
            end else if (busy_reg) begin
                unique case (op_reg)
                    bmse_pkg::U_MUL: begin
                        work_reg <= mul_next;
                        rem_reg  <= {rem_reg[bmse_pkg::REM_W-2:0], 1'b0};
                    end
                    bmse_pkg::U_DIV: begin
                        work_reg <= {work_reg[bmse_pkg::WIDE_W-2:0], div_ge};
                        rem_reg  <= {{(bmse_pkg::REM_W-bmse_pkg::CFG_W){1'b0}},
                                     div_ge ? bmse_pkg::CFG_W'(div_top - div_d)
                                            : div_top[bmse_pkg::CFG_W-1:0]};
                    end
                    default: begin
                        work_reg <= {work_reg[bmse_pkg::WIDE_W-3:0], 2'b00};
                        rem_reg  <= sq_ge ? (sq_top - sq_trial) : sq_top;
                        aux_reg  <= {aux_reg[bmse_pkg::ROOT_W-2:0], sq_ge};
                    end
                endcase
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == cnt_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == bmse_pkg::U_SQRT)
                     ? {{(bmse_pkg::WIDE_W-bmse_pkg::ROOT_W){1'b0}}, aux_reg}
                     : work_reg;

endmodule

`default_nettype wire

>>> src/batch_means_std_error.sv
// Batch-means standard error block: top level with sequencer, accumulators and APB registers.
// Depends on bmse_pkg and bmse_iter.
//
//  Channel   Dir  Handshake           Payload
//  s_        in   s_valid / s_ready   s_op, s_price
//  m_        out  m_valid / m_ready   m_mean, m_std_error, m_last_sample, m_status
//  APB       in   psel/penable/pready paddr, pwdata, prdata (paths_per_batch @0, batch_count @4)
//
// Sequence: an add that does not close a batch, a clear and an ignored op are handled in the idle state.
// An add that closes a batch runs a divide (the batch mean) and then a square of it.
// A full report runs a divide, a square, a divide, a divide by batch_count minus one and a square root; one with an
// incomplete batch or batch_count of one is shorter. The shared bmse_iter unit does all of this arithmetic.
// Reset: synchronous, active low; clears the accumulators and sets both registers to one.
// Stalls: s_ready is low while the sequencer runs; a held result in the output register
// does not block new input, but a second report waits in its last state for it to drain.
`default_nettype none

module batch_means_std_error (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input transactions
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_op,
    input  wire logic signed [bmse_pkg::SAMPLE_W-1:0] s_price,
    // result transactions
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [bmse_pkg::SAMPLE_W-1:0]   m_mean,
    output logic [bmse_pkg::SE_W-1:0]              m_std_error,
    output logic signed [bmse_pkg::SAMPLE_W-1:0]   m_last_sample,
    output logic [1:0]                             m_status,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int ACC_W  = bmse_pkg::ACC_W;
    localparam int WIDE_W = bmse_pkg::WIDE_W;
    localparam int CFG_W  = bmse_pkg::CFG_W;
    localparam int SMP_W  = bmse_pkg::SAMPLE_W;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] MEAN_HI = ACC_W'((64'sd1 <<< (SMP_W-1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] MEAN_LO = -MEAN_HI - ACC_W'(1);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_BMDIV = 16'h0002,
        S_BMW   = 16'h0004,
        S_BMMUL = 16'h0008,
        S_BMMW  = 16'h0010,
        S_MDIV  = 16'h0020,
        S_MW    = 16'h0040,
        S_MMUL  = 16'h0080,
        S_MMW   = 16'h0100,
        S_SDIV  = 16'h0200,
        S_SDW   = 16'h0400,
        S_VDIV  = 16'h0800,
        S_VDW   = 16'h1000,
        S_SQRT  = 16'h2000,
        S_SQW   = 16'h4000,
        S_FIN   = 16'h8000
    } state_t;

    function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] v);
        abs64 = v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    state_t                      state_reg;
    logic [CFG_W-1:0]            ppb_reg;
    logic [CFG_W-1:0]            bc_reg;
    logic [CFG_W-1:0]            pos_reg;
    logic [ACC_W-1:0]            bt_reg;
    logic [ACC_W-1:0]            mt_reg;
    logic [WIDE_W-1:0]           sq_reg;
    logic [SMP_W-1:0]            prev_reg;
    logic                        satf_reg;
    logic                        neg_reg;
    logic [ACC_W-1:0]            q_reg;
    logic [WIDE_W-1:0]           tmp_reg;
    logic                        rsat_reg;
    logic                        inc_reg;
    logic [SMP_W-1:0]            mean_reg;
    logic [bmse_pkg::SE_W-1:0]   se_reg;
    logic                        m_valid_reg;
    logic [SMP_W-1:0]            m_mean_reg;
    logic [bmse_pkg::SE_W-1:0]   m_se_reg;
    logic [SMP_W-1:0]            m_last_reg;
    logic [1:0]                  m_status_reg;

    bmse_pkg::unit_cmd_t         unit_cmd;
    bmse_pkg::unit_stat_t        unit_stat;
    logic [WIDE_W-1:0]           unit_a;
    logic [CFG_W-1:0]            unit_div;
    logic [WIDE_W-1:0]           unit_res;

    logic [CFG_W-1:0]            ppb_eff;
    logic [CFG_W-1:0]            n_eff;
    logic [ACC_W-1:0]            sample_ext;
    logic [ACC_W-1:0]            bt_sum;
    logic                        bt_ovf;
    logic [ACC_W-1:0]            bt_new;
    logic [CFG_W-1:0]            pos_inc;
    logic [ACC_W-1:0]            qv;
    logic [ACC_W-1:0]            sq_quot;
    logic [ACC_W-1:0]            mt_sum;
    logic                        mt_ovf;
    logic [WIDE_W:0]             sq_sum;
    logic                        mean_hi_clip;
    logic                        mean_lo_clip;
    logic                        se_clip;
    logic                        accept;
    logic                        out_load;

    assign ppb_eff    = (ppb_reg == '0) ? CFG_W'(1) : ppb_reg;
    assign n_eff      = (bc_reg == '0) ? CFG_W'(1) : bc_reg;
    assign sample_ext = {{(ACC_W-SMP_W){s_price[SMP_W-1]}}, s_price};
    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);

    // saturating batch sum
    assign bt_sum = bt_reg + sample_ext;
    assign bt_ovf = (bt_reg[ACC_W-1] == sample_ext[ACC_W-1])
                 && (bt_sum[ACC_W-1] != bt_reg[ACC_W-1]);
    assign bt_new = bt_ovf ? (bt_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : bt_sum;
    assign pos_inc = pos_reg + 1'b1;

    // signed quotient from the unit's magnitude quotient
    assign sq_quot = unit_res[ACC_W-1:0];
    assign qv      = neg_reg ? (~sq_quot + 1'b1) : sq_quot;

    assign mt_sum = mt_reg + qv;
    assign mt_ovf = (mt_reg[ACC_W-1] == qv[ACC_W-1]) && (mt_sum[ACC_W-1] != mt_reg[ACC_W-1]);
    assign sq_sum = {1'b0, sq_reg} + {1'b0, unit_res};

    assign mean_hi_clip = ($signed(qv) > MEAN_HI);
    assign mean_lo_clip = ($signed(qv) < MEAN_LO);
    assign se_clip      = (unit_res[bmse_pkg::ROOT_W-1:bmse_pkg::SE_W] != '0);

    // operand select and start for the shared unit
    always_comb begin
        unit_a        = '0;
        unit_div      = n_eff;
        unit_cmd.start = 1'b0;
        unit_cmd.op    = bmse_pkg::U_DIV;
        unique case (state_reg)
            S_BMDIV: begin
                unit_cmd.start = 1'b1;
                unit_a   = {{(WIDE_W-ACC_W){1'b0}}, abs64(bt_reg)};
                unit_div = ppb_eff;
            end
            S_MDIV: begin
                unit_cmd.start = 1'b1;
                unit_a = {{(WIDE_W-ACC_W){1'b0}}, abs64(mt_reg)};
            end
            S_SDIV: begin
                unit_cmd.start = 1'b1;
                unit_a = sq_reg;
            end
            S_VDIV: begin
                unit_cmd.start = 1'b1;
                unit_a   = tmp_reg;
                unit_div = n_eff - 1'b1;
            end
            S_BMMUL, S_MMUL: begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = bmse_pkg::U_MUL;
                unit_a = {{(WIDE_W-ACC_W){1'b0}}, q_reg};
            end
            S_SQRT: begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = bmse_pkg::U_SQRT;
                unit_a = tmp_reg;
            end
            default: begin
                unit_cmd.start = 1'b0;
            end
        endcase
    end

    bmse_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (unit_cmd),
        .opnd_a  (unit_a),
        .divisor (unit_div),
        .stat    (unit_stat),
        .result  (unit_res)
    );

    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // sequencer and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            bt_reg    <= '0;
            mt_reg    <= '0;
            sq_reg    <= '0;
            prev_reg  <= '0;
            satf_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (s_op)
                            bmse_pkg::OP_ADD: begin
                                prev_reg <= s_price;
                                bt_reg   <= bt_new;
                                satf_reg <= satf_reg | bt_ovf;
                                pos_reg  <= pos_inc;
                                if (pos_inc >= ppb_eff) begin
                                    state_reg <= S_BMDIV;
                                end
                            end
                            bmse_pkg::OP_REPORT: begin
                                rsat_reg <= satf_reg;
                                if (pos_reg != '0) begin
                                    inc_reg   <= 1'b1;
                                    mean_reg  <= '0;
                                    se_reg    <= '0;
                                    state_reg <= S_FIN;
                                end else begin
                                    inc_reg   <= 1'b0;
                                    state_reg <= S_MDIV;
                                end
                            end
                            bmse_pkg::OP_CLEAR: begin
                                pos_reg  <= '0;
                                bt_reg   <= '0;
                                mt_reg   <= '0;
                                sq_reg   <= '0;
                                satf_reg <= 1'b0;
                            end
                            default: begin
                                // drop the unused op code
                            end
                        endcase
                    end
                end
                S_BMDIV: begin
                    neg_reg   <= bt_reg[ACC_W-1];
                    bt_reg    <= '0;
                    pos_reg   <= '0;
                    state_reg <= S_BMW;
                end
                S_BMW: begin
                    if (unit_stat.done) begin
                        q_reg     <= sq_quot;
                        mt_reg    <= mt_ovf ? (mt_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : mt_sum;
                        satf_reg  <= satf_reg | mt_ovf;
                        state_reg <= S_BMMUL;
                    end
                end
                S_BMMUL: state_reg <= S_BMMW;
                S_BMMW: begin
                    if (unit_stat.done) begin
                        sq_reg    <= sq_sum[WIDE_W] ? '1 : sq_sum[WIDE_W-1:0];
                        satf_reg  <= satf_reg | sq_sum[WIDE_W];
                        state_reg <= S_IDLE;
                    end
                end
                S_MDIV: begin
                    neg_reg   <= mt_reg[ACC_W-1];
                    state_reg <= S_MW;
                end
                S_MW: begin
                    if (unit_stat.done) begin
                        q_reg    <= sq_quot;
                        se_reg   <= '0;
                        rsat_reg <= rsat_reg | mean_hi_clip | mean_lo_clip;
                        if (mean_hi_clip) begin
                            mean_reg <= MEAN_HI[SMP_W-1:0];
                        end else if (mean_lo_clip) begin
                            mean_reg <= MEAN_LO[SMP_W-1:0];
                        end else begin
                            mean_reg <= qv[SMP_W-1:0];
                        end
                        state_reg <= (n_eff > CFG_W'(1)) ? S_MMUL : S_FIN;
                    end
                end
                S_MMUL: state_reg <= S_MMW;
                S_MMW: begin
                    if (unit_stat.done) begin
                        tmp_reg   <= unit_res;
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV: state_reg <= S_SDW;
                S_SDW: begin
                    if (unit_stat.done) begin
                        if (unit_res > tmp_reg) begin
                            tmp_reg   <= unit_res - tmp_reg;
                            state_reg <= S_VDIV;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_VDIV: state_reg <= S_VDW;
                S_VDW: begin
                    if (unit_stat.done) begin
                        tmp_reg   <= unit_res;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: state_reg <= S_SQW;
                S_SQW: begin
                    if (unit_stat.done) begin
                        se_reg    <= se_clip ? '1 : unit_res[bmse_pkg::SE_W-1:0];
                        rsat_reg  <= rsat_reg | se_clip;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg  <= 1'b1;
            m_mean_reg   <= mean_reg;
            m_se_reg     <= se_reg;
            m_last_reg   <= prev_reg;
            m_status_reg <= inc_reg ? bmse_pkg::ST_INCOMPLETE
                                    : (rsat_reg ? bmse_pkg::ST_SATURATED : bmse_pkg::ST_OK);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mean        = m_mean_reg;
    assign m_std_error   = m_se_reg;
    assign m_last_sample = m_last_reg;
    assign m_status      = m_status_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppb_reg <= CFG_W'(1);
            bc_reg  <= CFG_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                bc_reg <= pwdata[CFG_W-1:0];
            end else begin
                ppb_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = {{(32-CFG_W){1'b0}}, paddr[2] ? bc_reg : ppb_reg};
    assign pready = 1'b1;

    // the unit is only started when free
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_cmd.start |-> !unit_stat.busy)
        else $error("unit started while busy");

    // the unit is quiet whenever new input is taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !unit_stat.busy)
        else $error("unit busy while accepting input");

    // a result appears only from the final state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result without finished report");

    // incomplete batch reports carry no mean or error
    a_incomplete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == bmse_pkg::ST_INCOMPLETE) |-> (m_mean == '0 && m_std_error == '0))
        else $error("incomplete report with nonzero values");

endmodule

`default_nettype wire
